>>> hw/rtl/tpc_pkg.sv
package tpc_pkg;

    // field and register widths
    localparam int COORD_W    = 32;
    localparam int ROW_W      = 32;
    localparam int COS_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ROW_IDX_W  = 3;
    localparam int NUM_ROWS   = 8;

    // ray arithmetic widths
    localparam int DIFF_W = COORD_W + 1;          // point minus center
    localparam int PROD_W = 2 * DIFF_W;           // one component product
    localparam int SUM_W  = PROD_W + 2;           // signed sum of three products
    localparam int MAG_W  = SUM_W - 1;            // magnitude of that sum
    localparam int LO_W   = (MAG_W + 1) / 2;      // low limb of a split operand
    localparam int HI_W   = MAG_W - LO_W;         // high limb
    localparam int PP_LIMB_W = 2 * LO_W;          // limb by limb product
    localparam int SQ_W   = 2 * MAG_W;            // |r1|*|r2| and d*d

    // threshold side: c^2 * r1 * r2
    localparam int C2_W    = 2 * COS_W;
    localparam int LIMB_W  = LO_W;
    localparam int NLIMB   = (SQ_W + LIMB_W - 1) / LIMB_W;
    localparam int PAD_W   = NLIMB * LIMB_W;
    localparam int CPP_W   = C2_W + LIMB_W;
    localparam int RHS_W   = PAD_W + C2_W;
    localparam int COS_SHIFT = 2 * (COS_W - 1);   // (2^15)^2

    localparam logic [COS_W-1:0] COS_ONE  = COS_W'(32768);
    localparam logic [C2_W-1:0]  C2_RESET = C2_W'(COS_ONE) * C2_W'(COS_ONE);

    // depth test widths
    localparam int DPROD_W    = ROW_W + COORD_W;
    localparam int DSUM_W     = DPROD_W + 2;
    localparam int OFFS_SHIFT = 16;               // offset times 1.0 in Q16.16

    // pipeline length, input register to output register
    localparam int NUM_STG = 10;

    typedef enum logic {
        OP_TEST = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_A_X = 3'd0,
        CFG_CENTER_A_Y = 3'd1,
        CFG_CENTER_A_Z = 3'd2,
        CFG_CENTER_B_X = 3'd3,
        CFG_CENTER_B_Y = 3'd4,
        CFG_CENTER_B_Z = 3'd5,
        CFG_MIN_COS    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic ray_a_zero;
        logic ray_b_zero;
        logic front_a;
        logic front_b;
    } flags_t;

endpackage

>>> hw/rtl/triangulated_point_check.sv
// Triangulated point check. Each test word carries one Q16.16 point; the block
// forms the rays from the two configured camera centers, tests the folded ray
// angle on its exact squared cosine (|d|*2^15 <= c*|ra|*|rb|) and tests the
// point against the two loaded depth rows (row dot point plus offset > 0).
// Load words write one depth-row word and give no result. The arithmetic is a
// ten stage pipeline: a word enters every cycle unless every stage is full and
// the output side stalls. The depth of the pipeline is set by the wide
// products (split into 34-bit limbs, one multiply level per stage) and the
// 168-bit threshold compare. Each stage holds while the one after it is full
// and stalled, so empty stages keep filling while a result waits. The user
// must write configuration only while the pipeline is empty; the block does
// not enforce this. There is no clearing pass after reset.
module triangulated_point_check (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic signed [31:0]                  point_x,
    input  logic signed [31:0]                  point_y,
    input  logic signed [31:0]                  point_z,
    input  logic [2:0]                          word_index,
    input  logic signed [31:0]                  word_value,
    // result words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                keep,
    output logic                                angle_ok,
    output logic                                front_of_first,
    output logic                                front_of_second
);

    localparam int NS = tpc_pkg::NUM_STG;

    // ------------------------------------------------------------------
    // configuration and depth rows
    // ------------------------------------------------------------------
    logic [tpc_pkg::COORD_W-1:0]    ca_reg [3];
    logic [tpc_pkg::COORD_W-1:0]    cb_reg [3];
    logic [tpc_pkg::COS_W-1:0]      cos_reg;
    logic [tpc_pkg::C2_W-1:0]       c2_reg;
    logic [tpc_pkg::ROW_W-1:0]      rows_reg [tpc_pkg::NUM_ROWS];

    logic in_take;
    logic load_take;

    assign in_take   = in_valid && in_ready;
    assign load_take = in_take && (opcode == tpc_pkg::OP_LOAD);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ca_reg[k] <= '0;
                cb_reg[k] <= '0;
            end
            cos_reg <= tpc_pkg::COS_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tpc_pkg::CFG_CENTER_A_X: ca_reg[0] <= cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::CFG_CENTER_A_Y: ca_reg[1] <= cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::CFG_CENTER_A_Z: ca_reg[2] <= cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::CFG_CENTER_B_X: cb_reg[0] <= cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::CFG_CENTER_B_Y: cb_reg[1] <= cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::CFG_CENTER_B_Z: cb_reg[2] <= cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::CFG_MIN_COS:    cos_reg   <= cfg_data[tpc_pkg::COS_W-1:0];
                default: ;
            endcase
        end
    end

    // squared threshold, follows the register in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_reg <= tpc_pkg::C2_RESET;
        else
            c2_reg <= tpc_pkg::C2_W'(cos_reg) * tpc_pkg::C2_W'(cos_reg);
    end

    // depth-row loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tpc_pkg::NUM_ROWS; k++)
                rows_reg[k] <= '0;
        end
        else if (load_take)
        begin
            rows_reg[word_index] <= word_value;
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] adv;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
            adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
            vld_next[0] = in_valid && (opcode == tpc_pkg::OP_TEST);
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
                vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // stage 1: point capture
    // ------------------------------------------------------------------
    logic signed [tpc_pkg::COORD_W-1:0] s1_p_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_p_reg[0] <= point_x[tpc_pkg::COORD_W-1:0];
            s1_p_reg[1] <= point_y[tpc_pkg::COORD_W-1:0];
            s1_p_reg[2] <= point_z[tpc_pkg::COORD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: ray vectors, depth-row products
    // ------------------------------------------------------------------
    logic signed [tpc_pkg::COORD_W-1:0] ca_s [3];
    logic signed [tpc_pkg::COORD_W-1:0] cb_s [3];
    logic signed [tpc_pkg::ROW_W-1:0]   row_a_s [4];
    logic signed [tpc_pkg::ROW_W-1:0]   row_b_s [4];
    logic signed [tpc_pkg::DIFF_W-1:0]  s2_da_next [3];
    logic signed [tpc_pkg::DIFF_W-1:0]  s2_db_next [3];
    logic signed [tpc_pkg::DPROD_W-1:0] s2_dpa_next [3];
    logic signed [tpc_pkg::DPROD_W-1:0] s2_dpb_next [3];
    tpc_pkg::flags_t                    s2_flags_next;

    logic signed [tpc_pkg::DIFF_W-1:0]  s2_da_reg [3];
    logic signed [tpc_pkg::DIFF_W-1:0]  s2_db_reg [3];
    logic signed [tpc_pkg::DPROD_W-1:0] s2_dpa_reg [3];
    logic signed [tpc_pkg::DPROD_W-1:0] s2_dpb_reg [3];
    logic signed [tpc_pkg::ROW_W-1:0]   s2_offa_reg;
    logic signed [tpc_pkg::ROW_W-1:0]   s2_offb_reg;
    tpc_pkg::flags_t                    s2_flags_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            row_a_s[k] = rows_reg[k];
            row_b_s[k] = rows_reg[k+4];
        end
        for (int k = 0; k < 3; k++)
        begin
            ca_s[k]        = ca_reg[k];
            cb_s[k]        = cb_reg[k];
            s2_da_next[k]  = tpc_pkg::DIFF_W'(s1_p_reg[k]) - tpc_pkg::DIFF_W'(ca_s[k]);
            s2_db_next[k]  = tpc_pkg::DIFF_W'(s1_p_reg[k]) - tpc_pkg::DIFF_W'(cb_s[k]);
            s2_dpa_next[k] = tpc_pkg::DPROD_W'(row_a_s[k]) * tpc_pkg::DPROD_W'(s1_p_reg[k]);
            s2_dpb_next[k] = tpc_pkg::DPROD_W'(row_b_s[k]) * tpc_pkg::DPROD_W'(s1_p_reg[k]);
        end
        s2_flags_next.ray_a_zero = (s2_da_next[0] == '0) && (s2_da_next[1] == '0)
                                && (s2_da_next[2] == '0);
        s2_flags_next.ray_b_zero = (s2_db_next[0] == '0) && (s2_db_next[1] == '0)
                                && (s2_db_next[2] == '0);
        s2_flags_next.front_a    = 1'b0;
        s2_flags_next.front_b    = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_da_reg[k]  <= s2_da_next[k];
                s2_db_reg[k]  <= s2_db_next[k];
                s2_dpa_reg[k] <= s2_dpa_next[k];
                s2_dpb_reg[k] <= s2_dpb_next[k];
            end
            s2_offa_reg  <= row_a_s[3];
            s2_offb_reg  <= row_b_s[3];
            s2_flags_reg <= s2_flags_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: component products, depth sums
    // ------------------------------------------------------------------
    logic signed [tpc_pkg::PROD_W-1:0] s3_sqa_next [3];
    logic signed [tpc_pkg::PROD_W-1:0] s3_sqb_next [3];
    logic signed [tpc_pkg::PROD_W-1:0] s3_cr_next [3];
    logic signed [tpc_pkg::DSUM_W-1:0] s3_dsa_next;
    logic signed [tpc_pkg::DSUM_W-1:0] s3_dsb_next;

    logic signed [tpc_pkg::PROD_W-1:0] s3_sqa_reg [3];
    logic signed [tpc_pkg::PROD_W-1:0] s3_sqb_reg [3];
    logic signed [tpc_pkg::PROD_W-1:0] s3_cr_reg [3];
    logic signed [tpc_pkg::DSUM_W-1:0] s3_dsa_reg;
    logic signed [tpc_pkg::DSUM_W-1:0] s3_dsb_reg;
    tpc_pkg::flags_t                   s3_flags_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s3_sqa_next[k] = tpc_pkg::PROD_W'(s2_da_reg[k]) * tpc_pkg::PROD_W'(s2_da_reg[k]);
            s3_sqb_next[k] = tpc_pkg::PROD_W'(s2_db_reg[k]) * tpc_pkg::PROD_W'(s2_db_reg[k]);
            s3_cr_next[k]  = tpc_pkg::PROD_W'(s2_da_reg[k]) * tpc_pkg::PROD_W'(s2_db_reg[k]);
        end
        s3_dsa_next = tpc_pkg::DSUM_W'(s2_dpa_reg[0]) + tpc_pkg::DSUM_W'(s2_dpa_reg[1])
                    + tpc_pkg::DSUM_W'(s2_dpa_reg[2])
                    + (tpc_pkg::DSUM_W'(s2_offa_reg) <<< tpc_pkg::OFFS_SHIFT);
        s3_dsb_next = tpc_pkg::DSUM_W'(s2_dpb_reg[0]) + tpc_pkg::DSUM_W'(s2_dpb_reg[1])
                    + tpc_pkg::DSUM_W'(s2_dpb_reg[2])
                    + (tpc_pkg::DSUM_W'(s2_offb_reg) <<< tpc_pkg::OFFS_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_sqa_reg[k] <= s3_sqa_next[k];
                s3_sqb_reg[k] <= s3_sqb_next[k];
                s3_cr_reg[k]  <= s3_cr_next[k];
            end
            s3_dsa_reg   <= s3_dsa_next;
            s3_dsb_reg   <= s3_dsb_next;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squared ray lengths, ray dot product, depth signs
    // ------------------------------------------------------------------
    logic signed [tpc_pkg::SUM_W-1:0] r1_sum;
    logic signed [tpc_pkg::SUM_W-1:0] r2_sum;
    logic signed [tpc_pkg::SUM_W-1:0] s4_d_next;
    tpc_pkg::flags_t                  s4_flags_next;

    logic [tpc_pkg::MAG_W-1:0]        s4_r1_reg;
    logic [tpc_pkg::MAG_W-1:0]        s4_r2_reg;
    logic signed [tpc_pkg::SUM_W-1:0] s4_d_reg;
    tpc_pkg::flags_t                  s4_flags_reg;

    always_comb
    begin
        r1_sum = tpc_pkg::SUM_W'(s3_sqa_reg[0]) + tpc_pkg::SUM_W'(s3_sqa_reg[1])
               + tpc_pkg::SUM_W'(s3_sqa_reg[2]);
        r2_sum = tpc_pkg::SUM_W'(s3_sqb_reg[0]) + tpc_pkg::SUM_W'(s3_sqb_reg[1])
               + tpc_pkg::SUM_W'(s3_sqb_reg[2]);
        s4_d_next = tpc_pkg::SUM_W'(s3_cr_reg[0]) + tpc_pkg::SUM_W'(s3_cr_reg[1])
                  + tpc_pkg::SUM_W'(s3_cr_reg[2]);
        s4_flags_next         = s3_flags_reg;
        // strictly positive depth
        s4_flags_next.front_a = !s3_dsa_reg[tpc_pkg::DSUM_W-1] && (s3_dsa_reg != '0);
        s4_flags_next.front_b = !s3_dsb_reg[tpc_pkg::DSUM_W-1] && (s3_dsb_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_r1_reg    <= r1_sum[tpc_pkg::MAG_W-1:0];
            s4_r2_reg    <= r2_sum[tpc_pkg::MAG_W-1:0];
            s4_d_reg     <= s4_d_next;
            s4_flags_reg <= s4_flags_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: |d|
    // ------------------------------------------------------------------
    logic signed [tpc_pkg::SUM_W-1:0] d_neg;
    logic [tpc_pkg::MAG_W-1:0]        s5_dabs_next;

    logic [tpc_pkg::MAG_W-1:0]        s5_r1_reg;
    logic [tpc_pkg::MAG_W-1:0]        s5_r2_reg;
    logic [tpc_pkg::MAG_W-1:0]        s5_dabs_reg;
    tpc_pkg::flags_t                  s5_flags_reg;

    always_comb
    begin
        d_neg        = -s4_d_reg;
        s5_dabs_next = s4_d_reg[tpc_pkg::SUM_W-1] ? d_neg[tpc_pkg::MAG_W-1:0]
                                                  : s4_d_reg[tpc_pkg::MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_r1_reg    <= s4_r1_reg;
            s5_r2_reg    <= s4_r2_reg;
            s5_dabs_reg  <= s5_dabs_next;
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: limb products of r1*r2 and d*d
    // ------------------------------------------------------------------
    logic [tpc_pkg::LO_W-1:0]      r1_lo, r2_lo, d_lo;
    logic [tpc_pkg::HI_W-1:0]      r1_hi, r2_hi, d_hi;

    logic [tpc_pkg::PP_LIMB_W-1:0] s6_r_ll_reg, s6_r_lh_reg, s6_r_hl_reg, s6_r_hh_reg;
    logic [tpc_pkg::PP_LIMB_W-1:0] s6_d_ll_reg, s6_d_lh_reg, s6_d_hh_reg;
    tpc_pkg::flags_t               s6_flags_reg;

    assign r1_lo = s5_r1_reg[tpc_pkg::LO_W-1:0];
    assign r1_hi = s5_r1_reg[tpc_pkg::MAG_W-1:tpc_pkg::LO_W];
    assign r2_lo = s5_r2_reg[tpc_pkg::LO_W-1:0];
    assign r2_hi = s5_r2_reg[tpc_pkg::MAG_W-1:tpc_pkg::LO_W];
    assign d_lo  = s5_dabs_reg[tpc_pkg::LO_W-1:0];
    assign d_hi  = s5_dabs_reg[tpc_pkg::MAG_W-1:tpc_pkg::LO_W];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_r_ll_reg  <= tpc_pkg::PP_LIMB_W'(r1_lo) * tpc_pkg::PP_LIMB_W'(r2_lo);
            s6_r_lh_reg  <= tpc_pkg::PP_LIMB_W'(r1_lo) * tpc_pkg::PP_LIMB_W'(r2_hi);
            s6_r_hl_reg  <= tpc_pkg::PP_LIMB_W'(r1_hi) * tpc_pkg::PP_LIMB_W'(r2_lo);
            s6_r_hh_reg  <= tpc_pkg::PP_LIMB_W'(r1_hi) * tpc_pkg::PP_LIMB_W'(r2_hi);
            s6_d_ll_reg  <= tpc_pkg::PP_LIMB_W'(d_lo) * tpc_pkg::PP_LIMB_W'(d_lo);
            s6_d_lh_reg  <= tpc_pkg::PP_LIMB_W'(d_lo) * tpc_pkg::PP_LIMB_W'(d_hi);
            s6_d_hh_reg  <= tpc_pkg::PP_LIMB_W'(d_hi) * tpc_pkg::PP_LIMB_W'(d_hi);
            s6_flags_reg <= s5_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: assemble r1*r2 and d*d
    // ------------------------------------------------------------------
    logic [tpc_pkg::SQ_W-1:0] s7_r12_next;
    logic [tpc_pkg::SQ_W-1:0] s7_dd_next;

    logic [tpc_pkg::SQ_W-1:0] s7_r12_reg;
    logic [tpc_pkg::SQ_W-1:0] s7_dd_reg;
    tpc_pkg::flags_t          s7_flags_reg;

    always_comb
    begin
        s7_r12_next = tpc_pkg::SQ_W'(s6_r_ll_reg)
                    + (tpc_pkg::SQ_W'(s6_r_lh_reg) << tpc_pkg::LO_W)
                    + (tpc_pkg::SQ_W'(s6_r_hl_reg) << tpc_pkg::LO_W)
                    + (tpc_pkg::SQ_W'(s6_r_hh_reg) << (2 * tpc_pkg::LO_W));
        // cross term counted twice
        s7_dd_next  = tpc_pkg::SQ_W'(s6_d_ll_reg)
                    + (tpc_pkg::SQ_W'(s6_d_lh_reg) << (tpc_pkg::LO_W + 1))
                    + (tpc_pkg::SQ_W'(s6_d_hh_reg) << (2 * tpc_pkg::LO_W));
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_r12_reg   <= s7_r12_next;
            s7_dd_reg    <= s7_dd_next;
            s7_flags_reg <= s6_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: c^2 times r1*r2, one product per limb
    // ------------------------------------------------------------------
    logic [tpc_pkg::PAD_W-1:0] r12_pad;
    logic [tpc_pkg::CPP_W-1:0] s8_cpp_next [tpc_pkg::NLIMB];

    logic [tpc_pkg::CPP_W-1:0] s8_cpp_reg [tpc_pkg::NLIMB];
    logic [tpc_pkg::SQ_W-1:0]  s8_dd_reg;
    tpc_pkg::flags_t           s8_flags_reg;

    always_comb
    begin
        r12_pad = tpc_pkg::PAD_W'(s7_r12_reg);
        for (int j = 0; j < tpc_pkg::NLIMB; j++)
            s8_cpp_next[j] = tpc_pkg::CPP_W'(c2_reg)
                           * tpc_pkg::CPP_W'(r12_pad[j*tpc_pkg::LIMB_W +: tpc_pkg::LIMB_W]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            for (int j = 0; j < tpc_pkg::NLIMB; j++)
                s8_cpp_reg[j] <= s8_cpp_next[j];
            s8_dd_reg    <= s7_dd_reg;
            s8_flags_reg <= s7_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: sum the limb products
    // ------------------------------------------------------------------
    logic [tpc_pkg::RHS_W-1:0] s9_rhs_next;

    logic [tpc_pkg::RHS_W-1:0] s9_rhs_reg;
    logic [tpc_pkg::SQ_W-1:0]  s9_dd_reg;
    tpc_pkg::flags_t           s9_flags_reg;

    always_comb
    begin
        s9_rhs_next = '0;
        for (int j = 0; j < tpc_pkg::NLIMB; j++)
            s9_rhs_next = s9_rhs_next
                        + (tpc_pkg::RHS_W'(s8_cpp_reg[j]) << (j * tpc_pkg::LIMB_W));
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s9_rhs_reg   <= s9_rhs_next;
            s9_dd_reg    <= s8_dd_reg;
            s9_flags_reg <= s8_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: threshold compare, output register
    // ------------------------------------------------------------------
    logic [tpc_pkg::RHS_W-1:0] lhs;
    logic                      angle_next;

    logic keep_reg;
    logic angle_ok_reg;
    logic front_a_reg;
    logic front_b_reg;

    always_comb
    begin
        lhs = tpc_pkg::RHS_W'({s9_dd_reg, {tpc_pkg::COS_SHIFT{1'b0}}});
        // zero-length ray: angle 0, cosine 1
        if (s9_flags_reg.ray_a_zero || s9_flags_reg.ray_b_zero)
            angle_next = (cos_reg >= tpc_pkg::COS_ONE);
        else
            angle_next = (lhs <= s9_rhs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            angle_ok_reg <= angle_next;
            front_a_reg  <= s9_flags_reg.front_a;
            front_b_reg  <= s9_flags_reg.front_b;
            keep_reg     <= angle_next && s9_flags_reg.front_a && s9_flags_reg.front_b;
        end
    end

    assign keep            = keep_reg;
    assign angle_ok        = angle_ok_reg;
    assign front_of_first  = front_a_reg;
    assign front_of_second = front_b_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a load word never enters the arithmetic pipeline
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == tpc_pkg::OP_LOAD)) |=> !vld_reg[0])
        else $error("load word entered the pipeline");

    // with the output free, the whole pipeline moves
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("pipeline stalled with the output free");

    // an empty first stage always takes a word
    a_fill_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> in_ready)
        else $error("empty first stage refused a word");

endmodule
